// ----- src/erf_pkg.sv -----
package erf_pkg;

    localparam int COUNT_LIMIT = 2047;
    localparam int CNT_W = $clog2(COUNT_LIMIT + 1);
    localparam int LEN_W = 11;
    localparam int WIDE_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int HEADER_LEN = 14;
    localparam int LEN_MAX = 2047;
    localparam int MAC_W = 48;

    localparam logic [MAC_W-1:0] MAC_RESET = 48'h5254_0012_3456;
    localparam logic [7:0] BCAST_BYTE = 8'hFF;
    localparam logic [15:0] TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] TYPE_ARP = 16'h0806;

    typedef enum logic [2:0] {
        VERDICT_SHORT = 3'd0,
        VERDICT_NOT_US = 3'd1,
        VERDICT_IPV4 = 3'd2,
        VERDICT_ARP = 3'd3,
        VERDICT_OTHER = 3'd4
    } verdict_t;

endpackage

// ----- src/erf_if.sv -----
interface erf_in_if;
    logic valid;
    logic ready;
    logic [7:0] frame_byte;
    logic last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface erf_out_if;
    logic valid;
    logic ready;
    logic [2:0] verdict;
    logic [15:0] ether_type;
    logic [10:0] payload_length;

    modport source (output valid, output verdict, output ether_type, output payload_length,
                    input ready);
    modport sink (input valid, input verdict, input ether_type, input payload_length,
                  output ready);
endinterface

interface erf_cfg_if;
    logic valid;
    logic ready;
    logic [47:0] station_mac;

    modport source (output valid, output station_mac, input ready);
    modport sink (input valid, input station_mac, output ready);
endinterface

// ----- src/ethernet_receive_filter_top.sv -----
// Ethernet receive filter.
// frames: one frame byte per transaction in wire order, last_byte set on the
//   final byte. Bytes that are not last produce nothing.
// results: one transaction per frame carrying verdict, ether_type and
//   payload_length (short frames report zero type and length).
// cfg: writes the 48-bit station MAC; always ready. Write it between frames
//   or mid-frame; each destination byte uses the value held when it is
//   processed.
// Throughput: one byte per cycle while no result holds a last byte back. An
//   accepted byte sits in the input register and is processed from there;
//   processing a last byte loads the verdict into the result register, which
//   drives the result transaction.
// Stall: while a result waits, non-last bytes keep flowing; a following
//   last byte holds in the input register until the result is taken.
// Reset: station MAC returns to 52:54:00:12:34:56, frame state clears and
//   both registers empty. The byte counter saturates at COUNT_LIMIT.
module ethernet_receive_filter_top
    import erf_pkg::*;
(
    input logic clk,
    input logic rst_n,
    erf_in_if.sink frames,
    erf_out_if.source results,
    erf_cfg_if.sink cfg
);

    logic [MAC_W-1:0] mac_reg;

    logic s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic s1_last_reg;
    logic s1_fire;

    logic [CNT_W-1:0] count_reg, count_next;
    logic st_match_reg, st_match_next;
    logic bc_match_reg, bc_match_next;
    logic [15:0] type_reg, type_next;

    logic out_valid_reg;
    verdict_t verdict_reg, verdict_next;
    logic [15:0] etype_reg, etype_next;
    logic [LEN_W-1:0] plen_reg, plen_next;

    logic [7:0] mac_byte;
    logic [WIDE_W-1:0] total_w;
    logic [WIDE_W-1:0] diff_w;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mac_reg <= MAC_RESET;
        else if (cfg.valid)
            mac_reg <= cfg.station_mac;
    end

    // advance unless a last byte would overwrite an untaken result
    assign s1_fire = s1_valid_reg && (!s1_last_reg || !out_valid_reg || results.ready);
    assign frames.ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (frames.ready)
            s1_valid_reg <= frames.valid;
    end

    always_ff @(posedge clk)
    begin
        if (frames.ready && frames.valid)
        begin
            s1_byte_reg <= frames.frame_byte;
            s1_last_reg <= frames.last_byte;
        end
    end

    always_comb
    begin
        case (count_reg[2:0])
            3'd0: mac_byte = mac_reg[47:40];
            3'd1: mac_byte = mac_reg[39:32];
            3'd2: mac_byte = mac_reg[31:24];
            3'd3: mac_byte = mac_reg[23:16];
            3'd4: mac_byte = mac_reg[15:8];
            3'd5: mac_byte = mac_reg[7:0];
            default: mac_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        st_match_next = st_match_reg;
        bc_match_next = bc_match_reg;
        type_next = type_reg;
        if (count_reg < CNT_W'(6))
        begin
            if (s1_byte_reg != mac_byte)
                st_match_next = 1'b0;
            if (s1_byte_reg != BCAST_BYTE)
                bc_match_next = 1'b0;
        end
        else if (count_reg == CNT_W'(12))
            type_next = {s1_byte_reg, type_reg[7:0]};
        else if (count_reg == CNT_W'(13))
            type_next = {type_reg[15:8], s1_byte_reg};

        if (count_reg < CNT_W'(COUNT_LIMIT))
            count_next = count_reg + CNT_W'(1);
        else
            count_next = count_reg;
    end

    assign total_w = WIDE_W'(count_next);
    assign diff_w = total_w - WIDE_W'(HEADER_LEN);

    always_comb
    begin
        if (total_w < WIDE_W'(HEADER_LEN))
        begin
            verdict_next = VERDICT_SHORT;
            etype_next = 16'h0000;
            plen_next = '0;
        end
        else
        begin
            etype_next = type_next;
            if (diff_w > WIDE_W'(LEN_MAX))
                plen_next = LEN_W'(LEN_MAX);
            else
                plen_next = diff_w[LEN_W-1:0];
            if (!st_match_next && !bc_match_next)
                verdict_next = VERDICT_NOT_US;
            else if (type_next == TYPE_IPV4)
                verdict_next = VERDICT_IPV4;
            else if (type_next == TYPE_ARP)
                verdict_next = VERDICT_ARP;
            else
                verdict_next = VERDICT_OTHER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            st_match_reg <= 1'b1;
            bc_match_reg <= 1'b1;
            type_reg <= 16'h0000;
        end
        else if (s1_fire)
        begin
            if (s1_last_reg)
            begin
                count_reg <= '0;
                st_match_reg <= 1'b1;
                bc_match_reg <= 1'b1;
                type_reg <= 16'h0000;
            end
            else
            begin
                count_reg <= count_next;
                st_match_reg <= st_match_next;
                bc_match_reg <= bc_match_next;
                type_reg <= type_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire && s1_last_reg)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
        begin
            verdict_reg <= verdict_next;
            etype_reg <= etype_next;
            plen_reg <= plen_next;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.verdict = verdict_reg;
    assign results.ether_type = etype_reg;
    assign results.payload_length = plen_reg;

endmodule

// ----- src/erf_checker.sv -----
module erf_checker
    import erf_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_last,
    input logic out_valid,
    input logic out_ready,
    input logic [2:0] verdict,
    input logic [15:0] ether_type,
    input logic [10:0] payload_length
);

    logic [1:0] pending_reg;
    logic in_take, out_take;

    assign in_take = in_valid && in_ready && in_last;
    assign out_take = out_valid && out_ready;

    // frames whose last byte was taken but whose verdict is not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 2'd0;
        else if (in_take && !out_take)
            pending_reg <= pending_reg + 2'd1;
        else if (out_take && !in_take)
            pending_reg <= pending_reg - 2'd1;
    end

    a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result without a pending last byte");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 2'd2)
        else $error("more than two frames in flight");

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == VERDICT_SHORT |-> ether_type == 16'h0000
            && payload_length == 11'd0)
        else $error("short frame reports type or length");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(verdict)
            && $stable(ether_type) && $stable(payload_length))
        else $error("stalled result changed");

endmodule

bind ethernet_receive_filter_top erf_checker u_erf_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(frames.valid),
    .in_ready(frames.ready),
    .in_last(frames.last_byte),
    .out_valid(results.valid),
    .out_ready(results.ready),
    .verdict(results.verdict),
    .ether_type(results.ether_type),
    .payload_length(results.payload_length)
);

// ----- tb/sv/ethernet_receive_filter_top_tb.sv -----
`timescale 1ns / 1ps

module ethernet_receive_filter_top_tb;
    import erf_pkg::*;

    localparam int SETTLE_CYCLES = 5;
    localparam int TAIL_CYCLES = 10;
    localparam int RUN_LIMIT = 500000;
    localparam int PHASES = 6;

    typedef enum logic [1:0] {
        STEP_BYTE,
        STEP_WRITE,
        STEP_DRAIN
    } step_kind_t;

    typedef enum {
        ADDR_STATION,
        ADDR_BCAST,
        ADDR_MIXED,
        ADDR_NEAR,
        ADDR_RANDOM
    } addr_kind_t;

    typedef struct {
        step_kind_t kind;
        logic [7:0] data;
        logic last;
        int unsigned gap;
        logic [MAC_W-1:0] mac;
    } frame_step_t;

    typedef struct {
        verdict_t verdict;
        logic [15:0] ether_type;
        logic [LEN_W-1:0] payload_length;
    } frame_verdict_t;

    bit clk = 1'b0;
    logic rst_n;

    erf_in_if frames();
    erf_out_if results();
    erf_cfg_if cfg();

    ethernet_receive_filter_top u_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .frames(frames),
        .results(results),
        .cfg(cfg)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // stimulus plan and driver state
    frame_step_t step_q[$];
    frame_step_t cur_step;
    bit step_loaded;
    bit step_shown;
    int unsigned gap_left;
    int unsigned settle_left;
    logic [MAC_W-1:0] gen_mac = MAC_RESET;
    bit burst_mode;
    int bytes_queued;
    int writes_queued;

    // frame filter prediction
    frame_verdict_t verdict_q[$];
    frame_verdict_t want_verdict;
    logic [MAC_W-1:0] station_model;
    logic [CNT_W-1:0] rx_count;
    bit rx_station_ok;
    bit rx_bcast_ok;
    logic [15:0] rx_type;
    int results_pending;
    int unsigned ready_hold;
    bit quiet_stall;

    int error_count;
    int frames_checked;
    int bytes_taken;
    int verdict_seen[5];
    int unsigned cycle_count = 0;

    task automatic flag_error(input string msg);
        if (error_count < 40)
            $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic queue_byte(input logic [7:0] data, input logic last);
        frame_step_t s;
        s.kind = STEP_BYTE;
        s.data = data;
        s.last = last;
        s.gap = burst_mode ? 0 : $urandom_range(0, 7);
        s.mac = '0;
        step_q.push_back(s);
        bytes_queued++;
    endtask

    task automatic queue_write(input logic [MAC_W-1:0] mac);
        frame_step_t s;
        s = '{STEP_WRITE, 8'h00, 1'b0, 0, mac};
        step_q.push_back(s);
        gen_mac = mac;
        writes_queued++;
    endtask

    task automatic queue_drain();
        frame_step_t s;
        s = '{STEP_DRAIN, 8'h00, 1'b0, 0, '0};
        step_q.push_back(s);
    endtask

    // split_at < 0: no station MAC write inside the frame
    task automatic queue_frame(input int len, input addr_kind_t kind, input logic [15:0] etype,
                               input int split_at, input logic [MAC_W-1:0] split_mac);
        logic [7:0] mac_byte;
        logic [7:0] b;
        int flip_at;
        flip_at = $urandom_range(0, 5);
        for (int i = 0; i < len; i++)
        begin
            if (i == split_at)
                queue_write(split_mac);
            if (i < 6)
            begin
                mac_byte = gen_mac[47 - 8*i -: 8];
                case (kind)
                    ADDR_STATION: b = mac_byte;
                    ADDR_BCAST: b = BCAST_BYTE;
                    ADDR_MIXED: b = $urandom_range(0, 1) ? BCAST_BYTE : mac_byte;
                    ADDR_NEAR: b = (i == flip_at) ? mac_byte ^ (8'h01 << $urandom_range(0, 7))
                                                  : mac_byte;
                    default: b = 8'($urandom);
                endcase
            end
            else if (i == HEADER_LEN - 2)
                b = etype[15:8];
            else if (i == HEADER_LEN - 1)
                b = etype[7:0];
            else
                b = 8'($urandom);
            queue_byte(b, i == len - 1);
        end
    endtask

    task automatic queue_random_frame(output int len);
        addr_kind_t kind;
        logic [15:0] etype;
        int pick;
        int split_at;
        logic [MAC_W-1:0] split_mac;
        burst_mode = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 8)
            len = $urandom_range(1, HEADER_LEN - 1);
        else if (pick < 13)
            len = HEADER_LEN;
        else if (pick < 85)
            len = $urandom_range(HEADER_LEN + 1, 30);
        else
            len = $urandom_range(31, 90);
        pick = $urandom_range(0, 99);
        if (pick < 35)
            kind = ADDR_STATION;
        else if (pick < 55)
            kind = ADDR_BCAST;
        else if (pick < 70)
            kind = ADDR_MIXED;
        else if (pick < 85)
            kind = ADDR_NEAR;
        else
            kind = ADDR_RANDOM;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            etype = TYPE_IPV4;
        else if (pick < 60)
            etype = TYPE_ARP;
        else if (pick < 70)
            etype = (pick < 65 ? TYPE_IPV4 : TYPE_ARP) ^ (16'h0001 << $urandom_range(0, 15));
        else
            etype = 16'($urandom);
        // now and then change the station MAC in the middle of the address
        split_at = -1;
        split_mac = 48'({$urandom, $urandom});
        if (len > 1 && $urandom_range(0, 11) == 0)
            split_at = $urandom_range(1, (len > 6) ? 5 : len - 1);
        queue_frame(len, kind, etype, split_at, split_mac);
    endtask

    task automatic build_stimulus();
        logic [MAC_W-1:0] phase_mac [PHASES];
        int phase_bytes;
        int phase_frames;
        int len;
        phase_mac[0] = '0;
        phase_mac[1] = '1;
        phase_mac[2] = 48'({$urandom, $urandom});
        phase_mac[3] = MAC_RESET;
        phase_mac[4] = 48'({$urandom, $urandom});
        phase_mac[5] = 48'({$urandom, $urandom});

        // directed frames against the reset station MAC
        burst_mode = 1'b0;
        queue_frame(1, ADDR_BCAST, TYPE_ARP, -1, '0);
        queue_frame(HEADER_LEN, ADDR_STATION, TYPE_IPV4, -1, '0);
        queue_frame(10, ADDR_BCAST, TYPE_ARP, -1, '0);

        for (int p = 0; p < PHASES; p++)
        begin
            queue_write(phase_mac[p]);
            phase_bytes = 0;
            phase_frames = 0;
            while (phase_bytes < 210 || phase_frames < 9)
            begin
                queue_random_frame(len);
                phase_bytes += len;
                phase_frames++;
                if (p == 3 && phase_frames == 4)
                    queue_drain();
            end
        end
        queue_drain();
    endtask

    task automatic take_byte(input logic [7:0] b, input logic last);
        frame_verdict_t v;
        int unsigned len;
        int pos;
        pos = rx_count;
        if (pos < 6)
        begin
            if (b != station_model[47 - 8*pos -: 8])
                rx_station_ok = 1'b0;
            if (b != BCAST_BYTE)
                rx_bcast_ok = 1'b0;
        end
        else if (pos == HEADER_LEN - 2)
            rx_type[15:8] = b;
        else if (pos == HEADER_LEN - 1)
            rx_type[7:0] = b;
        if (rx_count < COUNT_LIMIT)
            rx_count++;
        if (last)
        begin
            if (rx_count < HEADER_LEN)
            begin
                v.verdict = VERDICT_SHORT;
                v.ether_type = '0;
                v.payload_length = '0;
            end
            else
            begin
                len = rx_count - HEADER_LEN;
                if (len > LEN_MAX)
                    len = LEN_MAX;
                v.ether_type = rx_type;
                v.payload_length = LEN_W'(len);
                if (!rx_station_ok && !rx_bcast_ok)
                    v.verdict = VERDICT_NOT_US;
                else if (rx_type == TYPE_IPV4)
                    v.verdict = VERDICT_IPV4;
                else if (rx_type == TYPE_ARP)
                    v.verdict = VERDICT_ARP;
                else
                    v.verdict = VERDICT_OTHER;
            end
            verdict_q.push_back(v);
            rx_count = '0;
            rx_station_ok = 1'b1;
            rx_bcast_ok = 1'b1;
            rx_type = '0;
        end
    endtask

    // driver: present queued steps; writes and drains wait until no verdict is outstanding
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames.valid <= 1'b0;
            frames.frame_byte <= '0;
            frames.last_byte <= 1'b0;
            cfg.valid <= 1'b0;
            cfg.station_mac <= '0;
            cur_step = '{STEP_DRAIN, 8'h00, 1'b0, 0, '0};
            step_loaded = 1'b0;
            step_shown = 1'b0;
        end
        else
        begin
            if (step_shown && ((frames.valid && frames.ready) || (cfg.valid && cfg.ready)))
                step_shown = 1'b0;
            if (!step_shown && !step_loaded && step_q.size() != 0)
            begin
                cur_step = step_q.pop_front();
                step_loaded = 1'b1;
                gap_left = cur_step.gap;
                settle_left = SETTLE_CYCLES;
            end
            if (step_loaded)
            begin
                if (cur_step.kind == STEP_BYTE)
                begin
                    if (gap_left == 0)
                    begin
                        step_loaded = 1'b0;
                        step_shown = 1'b1;
                    end
                    else
                        gap_left--;
                end
                else if (results_pending != 0)
                    settle_left = SETTLE_CYCLES;
                else if (settle_left != 0)
                    settle_left--;
                else
                begin
                    step_loaded = 1'b0;
                    step_shown = (cur_step.kind == STEP_WRITE);
                end
            end
            frames.valid <= step_shown && cur_step.kind == STEP_BYTE;
            frames.frame_byte <= cur_step.data;
            frames.last_byte <= cur_step.last;
            cfg.valid <= step_shown && cur_step.kind == STEP_WRITE;
            cfg.station_mac <= cur_step.mac;
        end
    end

    // monitor: predict on accepted bytes, check each verdict transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results.ready <= 1'b0;
            results_pending <= 0;
            station_model = MAC_RESET;
            rx_count = '0;
            rx_station_ok = 1'b1;
            rx_bcast_ok = 1'b1;
            rx_type = '0;
            ready_hold = 0;
            quiet_stall = 1'b0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                if (verdict_q.size() == 0)
                    flag_error($sformatf("verdict %0d with no frame outstanding",
                                         results.verdict));
                else
                begin
                    want_verdict = verdict_q.pop_front();
                    if (results.verdict !== want_verdict.verdict)
                        flag_error($sformatf("frame %0d verdict got %0d want %0d",
                                             frames_checked, results.verdict,
                                             want_verdict.verdict));
                    if (results.ether_type !== want_verdict.ether_type)
                        flag_error($sformatf("frame %0d ether_type got %h want %h",
                                             frames_checked, results.ether_type,
                                             want_verdict.ether_type));
                    if (results.payload_length !== want_verdict.payload_length)
                        flag_error($sformatf("frame %0d payload_length got %0d want %0d",
                                             frames_checked, results.payload_length,
                                             want_verdict.payload_length));
                    verdict_seen[want_verdict.verdict]++;
                end
                frames_checked++;
                ready_hold = quiet_stall ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 15) == 0)
                    quiet_stall = !quiet_stall;
            end
            else if (results.valid && ready_hold != 0)
                ready_hold--;
            if (cfg.valid && cfg.ready)
                station_model = cfg.station_mac;
            if (frames.valid && frames.ready)
            begin
                take_byte(frames.frame_byte, frames.last_byte);
                bytes_taken++;
            end
            results.ready <= (ready_hold == 0);
            results_pending <= verdict_q.size();
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        // idle the channels before the first edge
        frames.valid = 1'b0;
        frames.frame_byte = '0;
        frames.last_byte = 1'b0;
        cfg.valid = 1'b0;
        cfg.station_mac = '0;
        results.ready = 1'b0;
        rst_n = 1'b0;
        build_stimulus();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (step_q.size() != 0 || step_loaded || step_shown)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (verdict_q.size() != 0)
            flag_error($sformatf("%0d verdicts never arrived", verdict_q.size()));
        $display("covered %0d frames from %0d bytes with %0d station MAC writes",
                 frames_checked, bytes_taken, writes_queued);
        $display("verdicts: short %0d, not ours %0d, ipv4 %0d, arp %0d, other %0d",
                 verdict_seen[VERDICT_SHORT], verdict_seen[VERDICT_NOT_US],
                 verdict_seen[VERDICT_IPV4], verdict_seen[VERDICT_ARP],
                 verdict_seen[VERDICT_OTHER]);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
